/* hw/rtl/imgrot_pkg.sv */
package imgrot_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_FRAC_BITS  = 14;

    localparam int COORD_W    = 7;
    localparam int DIM_W      = 8;
    localparam int HALF_W     = 7;
    localparam int OFS_W      = 9;
    localparam int TRIG_W     = 16;
    localparam int PROD_W     = 25;
    localparam int SUM_W      = 26;
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_Q        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_Q        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd4;

    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 8'd128;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 8'd128;
    localparam logic [TRIG_W-1:0] RST_COS_Q        = 16'd16384;
    localparam logic [TRIG_W-1:0] RST_SIN_Q        = 16'd0;
    localparam logic [PIX_W-1:0]  RST_BG_COLOR     = 32'h00A0_9600;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]         w;
        logic [DIM_W-1:0]         h;
        logic [HALF_W-1:0]        half_w;
        logic [HALF_W-1:0]        half_h;
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
        logic [PIX_W-1:0]         bg_color;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic rd;
        logic wr_ok;
        logic in_img;
    } t_req_ctl;

endpackage

/* hw/rtl/imgrot_cfg.sv */
module imgrot_cfg
    import imgrot_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    logic [DIM_W-1:0]  r_image_width;
    logic [DIM_W-1:0]  r_image_height;
    logic [TRIG_W-1:0] r_cos_q;
    logic [TRIG_W-1:0] r_sin_q;
    logic [PIX_W-1:0]  r_bg_color;
    logic [DIM_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r, input int maxv);
        logic [DIM_W-1:0] d;
        if (r == '0) begin
            d = DIM_W'(1);
        end else if (int'(r) > maxv) begin
            d = DIM_W'(maxv);
        end else begin
            d = r;
        end
        return d;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_cos_q        <= RST_COS_Q;
            r_sin_q        <= RST_SIN_Q;
            r_bg_color     <= RST_BG_COLOR;
        end else if (i_wr_en) begin
            unique case (i_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_data[DIM_W-1:0];
                CFG_COS_Q:        r_cos_q        <= i_data[TRIG_W-1:0];
                CFG_SIN_Q:        r_sin_q        <= i_data[TRIG_W-1:0];
                CFG_BG_COLOR:     r_bg_color     <= i_data[PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign eff_w = eff_dim(r_image_width, MAX_WIDTH);
    assign eff_h = eff_dim(r_image_height, MAX_HEIGHT);

    always_comb begin
        o_cfg.w        = eff_w;
        o_cfg.h        = eff_h;
        o_cfg.half_w   = eff_w[DIM_W-1:1];
        o_cfg.half_h   = eff_h[DIM_W-1:1];
        o_cfg.cos_q    = $signed(r_cos_q);
        o_cfg.sin_q    = $signed(r_sin_q);
        o_cfg.bg_color = r_bg_color;
    end

endmodule

/* hw/rtl/imgrot_xform.sv */
module imgrot_xform
    import imgrot_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  logic [PIX_W-1:0]   i_pixel_in,
    input  t_cfg               i_cfg,
    output t_req_ctl           o_req,
    input  logic               i_req_ready,
    output logic [AW-1:0]      o_addr,
    output logic [PIX_W-1:0]   o_wdata
);

    localparam int NS = 6;
    localparam int XW = SUM_W + 1;
    localparam logic signed [SUM_W-1:0] BIAS   = SUM_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [SUM_W-1:0] ZERO_S = '0;

    logic [NS:1]            r_v;
    logic [NS+1:1]          rdy;
    logic                   r_op    [NS:1];
    logic                   r_wok   [NS:1];
    logic [PIX_W-1:0]       r_wdata [NS:1];
    logic [AW-1:0]          r_waddr [NS-1:1];

    logic signed [OFS_W-1:0]  r_x1, r_y1, n_x1, n_y1;
    logic                     n_wok1;
    logic [AW-1:0]            n_waddr1;
    logic signed [PROD_W-1:0] r_cx2, r_sy2, r_sx2, r_cy2;
    logic signed [PROD_W-1:0] n_cx2, n_sy2, n_sx2, n_cy2;
    logic signed [SUM_W-1:0]  r_u3, r_v3, n_u3, n_v3;
    logic signed [SUM_W-1:0]  n_bu, n_bv;
    logic signed [SUM_W-1:0]  r_tu4, r_tv4, n_tu4, n_tv4;
    logic signed [XW-1:0]     r_sx5, r_sy5, n_sx5, n_sy5;
    logic                     r_in6, n_in6;
    logic [AW-1:0]            r_addr6, n_addr6, n_raddr6;

    always_comb begin
        rdy[NS+1] = i_req_ready;
        for (int k = NS; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[1];

    always_comb begin
        n_x1     = $signed({2'b00, i_col}) - $signed({2'b00, i_cfg.half_w});
        n_y1     = $signed({2'b00, i_cfg.half_h}) - $signed({2'b00, i_row});
        n_wok1   = (int'(i_col) < MAX_WIDTH) && (int'(i_row) < MAX_HEIGHT);
        n_waddr1 = AW'(i_row) * AW'(MAX_WIDTH) + AW'(i_col);

        n_cx2 = PROD_W'(r_x1) * PROD_W'(i_cfg.cos_q);
        n_sy2 = PROD_W'(r_y1) * PROD_W'(i_cfg.sin_q);
        n_sx2 = PROD_W'(r_x1) * PROD_W'(i_cfg.sin_q);
        n_cy2 = PROD_W'(r_y1) * PROD_W'(i_cfg.cos_q);

        n_u3 = SUM_W'(r_cx2) - SUM_W'(r_sy2);
        n_v3 = SUM_W'(r_sx2) + SUM_W'(r_cy2);

        // Adding the bias to negative values makes the arithmetic shift round toward zero.
        n_bu  = r_u3 + (r_u3[SUM_W-1] ? BIAS : ZERO_S);
        n_bv  = r_v3 + (r_v3[SUM_W-1] ? BIAS : ZERO_S);
        n_tu4 = n_bu >>> FRAC_BITS;
        n_tv4 = n_bv >>> FRAC_BITS;

        n_sx5 = XW'(r_tu4) + XW'($signed({1'b0, i_cfg.half_w}));
        n_sy5 = XW'($signed({1'b0, i_cfg.half_h})) - XW'(r_tv4);

        n_in6 = !r_sx5[XW-1] && (r_sx5 < $signed(XW'(i_cfg.w)))
             && !r_sy5[XW-1] && (r_sy5 < $signed(XW'(i_cfg.h)));
        n_raddr6 = AW'($unsigned(r_sy5)) * AW'(MAX_WIDTH) + AW'($unsigned(r_sx5));
        n_addr6  = (r_op[NS-1] == OP_READ) ? n_raddr6 : r_waddr[NS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_op[1]    <= i_opcode;
            r_wok[1]   <= n_wok1;
            r_wdata[1] <= i_pixel_in;
            r_waddr[1] <= n_waddr1;
            r_x1       <= n_x1;
            r_y1       <= n_y1;
        end
        for (int k = 2; k <= NS; k++) begin
            if (rdy[k]) begin
                r_op[k]    <= r_op[k-1];
                r_wok[k]   <= r_wok[k-1];
                r_wdata[k] <= r_wdata[k-1];
            end
        end
        for (int k = 2; k <= NS - 1; k++) begin
            if (rdy[k]) begin
                r_waddr[k] <= r_waddr[k-1];
            end
        end
        if (rdy[2]) begin
            r_cx2 <= n_cx2;
            r_sy2 <= n_sy2;
            r_sx2 <= n_sx2;
            r_cy2 <= n_cy2;
        end
        if (rdy[3]) begin
            r_u3 <= n_u3;
            r_v3 <= n_v3;
        end
        if (rdy[4]) begin
            r_tu4 <= n_tu4;
            r_tv4 <= n_tv4;
        end
        if (rdy[5]) begin
            r_sx5 <= n_sx5;
            r_sy5 <= n_sy5;
        end
        if (rdy[6]) begin
            r_in6   <= n_in6;
            r_addr6 <= n_addr6;
        end
    end

    always_comb begin
        o_req.valid  = r_v[NS];
        o_req.rd     = (r_op[NS] == OP_READ);
        o_req.wr_ok  = r_wok[NS];
        o_req.in_img = r_in6;
    end

    assign o_addr  = r_addr6;
    assign o_wdata = r_wdata[NS];

endmodule

/* hw/rtl/imgrot_store.sv */
module imgrot_store
    import imgrot_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req_ctl         i_req,
    output logic             o_req_ready,
    input  logic [AW-1:0]    i_addr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic [PIX_W-1:0] i_bg_color,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_pixel_out,
    output logic             o_from_source
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;
    logic             r_v;
    logic             r_src;
    logic             accept;

    assign o_req_ready = !r_v || !i_stall;
    assign accept      = i_req.valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!i_req.rd && i_req.wr_ok) begin
                r_mem[i_addr] <= i_wdata;
            end
            if (i_req.rd && i_req.in_img) begin
                r_rdata <= r_mem[i_addr];
            end
        end
        if (o_req_ready) begin
            r_src <= i_req.in_img;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_req_ready) begin
            r_v <= i_req.valid && i_req.rd;
        end
    end

    assign o_valid       = r_v;
    assign o_from_source = r_src;
    assign o_pixel_out   = r_src ? r_rdata : i_bg_color;

endmodule

/* hw/rtl/image_rotate_nearest_top.sv */
// Nearest-neighbor image rotator over an on-chip frame store of MAX_WIDTH by MAX_HEIGHT
// 32-bit pixels. A write request stores a source pixel; a read request maps its output
// column and row back through the configured cosine and sine and returns the source pixel,
// or the background color when the source falls outside the configured image. One request
// is taken every clock while o_stall is low, writes and reads mixed in any order, and a
// read presents its pixel after seven register stages: six coordinate stages (centering,
// the four multipliers, the two sums, truncation toward zero, re-centering, bounds check
// and address) and the registered read of the single-port frame store, where writes and
// reads are served in request order. The store is not cleared at reset, so each pixel
// must be written before any read maps onto it. Configuration may only be changed
// while no request is in flight.
module image_rotate_nearest_top
    import imgrot_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [COORD_W-1:0]    i_col,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_from_source,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    t_cfg             cfg;
    t_req_ctl         req;
    logic             req_ready;
    logic             in_ready;
    logic [AW-1:0]    req_addr;
    logic [PIX_W-1:0] req_wdata;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !in_ready;

    imgrot_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    imgrot_xform #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_xform (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (in_ready),
        .i_opcode    (i_opcode),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_pixel_in  (i_pixel_in),
        .i_cfg       (cfg),
        .o_req       (req),
        .i_req_ready (req_ready),
        .o_addr      (req_addr),
        .o_wdata     (req_wdata)
    );

    imgrot_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .o_req_ready   (req_ready),
        .i_addr        (req_addr),
        .i_wdata       (req_wdata),
        .i_bg_color    (cfg.bg_color),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_out   (o_pixel_out),
        .o_from_source (o_from_source)
    );

endmodule

/* sim/testbench.sv */
module testbench;
    import imgrot_pkg::*;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 130;
    localparam int PRESSURE_ITEMS   = 100;
    localparam int STEADY_ITEMS     = 200;
    localparam int STORE_DEPTH      = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             from_source;
    } t_rotated_pixel;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_opcode;
    logic [COORD_W-1:0]    i_col;
    logic [COORD_W-1:0]    i_row;
    logic [PIX_W-1:0]      i_pixel_in;
    logic                  o_valid;
    logic                  i_stall;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_from_source;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [DIM_W-1:0]         cfg_width;
    logic [DIM_W-1:0]         cfg_height;
    logic signed [TRIG_W-1:0] cfg_cos;
    logic signed [TRIG_W-1:0] cfg_sin;
    logic [PIX_W-1:0]         cfg_bg;

    logic [PIX_W-1:0] frame_model [STORE_DEPTH];
    bit               pixel_loaded [STORE_DEPTH];
    t_rotated_pixel   pending_pixels [$];
    t_rotated_pixel   checked_pixel;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int sent_count     = 0;
    bit quiet_mode     = 1'b0;
    bit long_hold_req  = 1'b0;

    image_rotate_nearest_top i_dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("image_rotate_nearest_top regression: fail");
            $finish;
        end
    end

    function automatic longint effective_dim(input logic [DIM_W-1:0] r, input int maxv);
        if (r == 0) return 1;
        if (r > maxv) return maxv;
        return r;
    endfunction

    function automatic longint trunc_toward_zero(input longint v);
        if (v < 0) return -((-v) >>> DEF_FRAC_BITS);
        return v >>> DEF_FRAC_BITS;
    endfunction

    function automatic bit map_to_source(input logic [COORD_W-1:0] col,
                                         input logic [COORD_W-1:0] row,
                                         output int sx, output int sy);
        longint w, h, x, y, u, v;
        w = effective_dim(cfg_width, DEF_MAX_WIDTH);
        h = effective_dim(cfg_height, DEF_MAX_HEIGHT);
        x = longint'(col) - w / 2;
        y = h / 2 - longint'(row);
        u = longint'(cfg_cos) * x - longint'(cfg_sin) * y;
        v = longint'(cfg_sin) * x + longint'(cfg_cos) * y;
        sx = int'(trunc_toward_zero(u) + w / 2);
        sy = int'(h / 2 - trunc_toward_zero(v));
        return sx >= 0 && sx < w && sy >= 0 && sy < h;
    endfunction

    function automatic logic [DIM_W-1:0] random_dim(input int maxv);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DIM_W'($urandom_range(maxv + 1, 255));
            2: return DIM_W'(1);
            3: return DIM_W'(maxv);
            default: return DIM_W'($urandom_range(1, maxv));
        endcase
    endfunction

    function automatic logic [TRIG_W-1:0] random_trig();
        case ($urandom_range(0, 6))
            0: return TRIG_W'($urandom);
            1: return '0;
            2: return RST_COS_Q;
            3: return -RST_COS_Q;
            default: return TRIG_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: result with none pending, expected none, actual %h/%b",
                         $time, o_pixel_out, o_from_source);
                mismatch_count++;
            end else begin
                checked_pixel = pending_pixels.pop_front();
                if (o_pixel_out !== checked_pixel.pixel) begin
                    $display("%0t: pixel_out mismatch, expected %h, actual %h",
                             $time, checked_pixel.pixel, o_pixel_out);
                    mismatch_count++;
                end
                if (o_from_source !== checked_pixel.from_source) begin
                    $display("%0t: from_source mismatch, expected %b, actual %b",
                             $time, checked_pixel.from_source, o_from_source);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_stall <= 1'b1;
                for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(negedge i_clk);
                long_hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic op, input logic [COORD_W-1:0] col,
                                input logic [COORD_W-1:0] row, input logic [PIX_W-1:0] pix);
        t_rotated_pixel prediction;
        int sx, sy;
        @(negedge i_clk);
        if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_col      <= col;
        i_row      <= row;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        if (op == OP_WRITE) begin
            frame_model[int'(row) * DEF_MAX_WIDTH + int'(col)] = pix;
            pixel_loaded[int'(row) * DEF_MAX_WIDTH + int'(col)] = 1'b1;
        end else begin
            if (map_to_source(col, row, sx, sy)) begin
                prediction.pixel = frame_model[sy * DEF_MAX_WIDTH + sx];
                prediction.from_source = 1'b1;
            end else begin
                prediction.pixel = cfg_bg;
                prediction.from_source = 1'b0;
            end
            pending_pixels.push_back(prediction);
        end
    endtask

    // A read whose source pixel was never stored gets a write request to it first.
    task automatic read_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        int sx, sy;
        if (map_to_source(col, row, sx, sy) && !pixel_loaded[sy * DEF_MAX_WIDTH + sx])
            send_request(OP_WRITE, sx[COORD_W-1:0], sy[COORD_W-1:0], $urandom);
        send_request(OP_READ, col, row, $urandom);
    endtask

    task automatic settle_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_width  = data[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: cfg_height = data[DIM_W-1:0];
            CFG_COS_Q:        cfg_cos    = data[TRIG_W-1:0];
            CFG_SIN_Q:        cfg_sin    = data[TRIG_W-1:0];
            CFG_BG_COLOR:     cfg_bg     = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                  input logic [TRIG_W-1:0] c, input logic [TRIG_W-1:0] s,
                                  input logic [PIX_W-1:0] bg);
        settle_pipeline();
        write_register(CFG_IMAGE_WIDTH, {(CFG_DATA_W - DIM_W)'($urandom), w});
        write_register(CFG_IMAGE_HEIGHT, {(CFG_DATA_W - DIM_W)'($urandom), h});
        write_register(CFG_COS_Q, {(CFG_DATA_W - TRIG_W)'($urandom), c});
        write_register(CFG_SIN_Q, {(CFG_DATA_W - TRIG_W)'($urandom), s});
        write_register(CFG_BG_COLOR, bg);
    endtask

    task automatic randomize_settings();
        apply_settings(random_dim(DEF_MAX_WIDTH), random_dim(DEF_MAX_HEIGHT),
                       random_trig(), random_trig(), $urandom);
    endtask

    task automatic run_random_items(input int count);
        int first;
        first = sent_count;
        while (sent_count - first < count) begin
            if ($urandom_range(0, 9) < 3)
                send_request(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom), $urandom);
            else
                read_pixel(COORD_W'($urandom), COORD_W'($urandom));
        end
    endtask

    task automatic test_identity_defaults();
        send_request(OP_WRITE, 7'd0, 7'd0, '0);
        send_request(OP_WRITE, 7'd127, 7'd127, '1);
        send_request(OP_WRITE, 7'd127, 7'd0, 32'hAAAA_AAAA);
        send_request(OP_WRITE, 7'd0, 7'd127, 32'h5555_5555);
        read_pixel(7'd0, 7'd0);
        read_pixel(7'd127, 7'd127);
        read_pixel(7'd127, 7'd0);
        read_pixel(7'd0, 7'd127);
        read_pixel(7'd64, 7'd64);
    endtask

    task automatic test_dimension_clamp();
        apply_settings('0, '1, RST_COS_Q, RST_SIN_Q, $urandom);
        read_pixel(7'd0, 7'd0);
        read_pixel(7'd127, 7'd127);
        read_pixel(7'd1, 7'd64);
        apply_settings('1, '0, RST_COS_Q, RST_SIN_Q, $urandom);
        read_pixel(7'd127, 7'd0);
        read_pixel(7'd0, 7'd0);
        read_pixel(7'd3, 7'd1);
    endtask

    task automatic test_trig_extremes();
        apply_settings(DIM_W'(DEF_MAX_WIDTH), DIM_W'(DEF_MAX_HEIGHT),
                       16'h8000, 16'h7FFF, $urandom);
        read_pixel(7'd0, 7'd0);
        read_pixel(7'd127, 7'd127);
        apply_settings(DIM_W'(DEF_MAX_WIDTH), DIM_W'(DEF_MAX_HEIGHT),
                       16'h7FFF, 16'h8000, $urandom);
        read_pixel(7'd127, 7'd0);
        read_pixel(7'd0, 7'd127);
        apply_settings(DIM_W'(DEF_MAX_WIDTH), DIM_W'(DEF_MAX_HEIGHT),
                       '0, RST_COS_Q, $urandom);
        read_pixel(7'd10, 7'd20);
    endtask

    task automatic test_read_outside_image();
        apply_settings(DIM_W'(16), DIM_W'(16), RST_COS_Q, RST_SIN_Q, $urandom);
        read_pixel(7'd100, 7'd3);
        read_pixel(7'd3, 7'd100);
        read_pixel(7'd15, 7'd15);
    endtask

    task automatic test_unknown_register();
        settle_pipeline();
        for (int k = CFG_BG_COLOR + 1; k < (1 << CFG_IDX_W); k++)
            write_register(CFG_IDX_W'(k), $urandom);
        read_pixel(7'd5, 7'd5);
        read_pixel(7'd8, 7'd0);
    endtask

    task automatic test_random_rotation();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            randomize_settings();
            run_random_items(PHASE_ITEMS);
        end
    endtask

    task automatic test_backpressure();
        randomize_settings();
        long_hold_req = 1'b1;
        run_random_items(PRESSURE_ITEMS);
    endtask

    task automatic test_steady_stream();
        randomize_settings();
        quiet_mode = 1'b1;
        run_random_items(STEADY_ITEMS);
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_opcode    = OP_WRITE;
        i_col       = '0;
        i_row       = '0;
        i_pixel_in  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IMAGE_WIDTH;
        i_cfg_data  = '0;
        cfg_width   = RST_IMAGE_WIDTH;
        cfg_height  = RST_IMAGE_HEIGHT;
        cfg_cos     = RST_COS_Q;
        cfg_sin     = RST_SIN_Q;
        cfg_bg      = RST_BG_COLOR;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_identity_defaults();
        test_dimension_clamp();
        test_trig_extremes();
        test_read_outside_image();
        test_unknown_register();
        test_random_rotation();
        test_backpressure();
        test_steady_stream();

        settle_pipeline();
        if (mismatch_count == 0) begin
            $display("image_rotate_nearest_top regression: pass");
        end else begin
            $display("image_rotate_nearest_top regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/imgrot_pkg.sv
hw/rtl/imgrot_cfg.sv
hw/rtl/imgrot_xform.sv
hw/rtl/imgrot_store.sv
hw/rtl/image_rotate_nearest_top.sv
sim/testbench.sv
